FILE: src/system_coprocessor_registers_unit_defines.svh
// Assertion macros shared by the system coprocessor register checks.
`ifndef SYSTEM_COPROCESSOR_REGISTERS_UNIT_DEFINES_SVH
`define SYSTEM_COPROCESSOR_REGISTERS_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SCR_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scr check failed");

// Next-cycle implication, held off while reset is asserted.
`define SCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scr check failed");

`endif

FILE: src/scr_pkg.sv
// Package: operation codes, register numbers, masks and shared types.
`default_nettype none
package scr_pkg;

    localparam int REG_COUNT = 32;

    typedef logic [2:0]  t_func;
    typedef logic [4:0]  t_reg_idx;
    typedef logic [31:0] t_word;

    localparam t_func FUNC_READ  = 3'd0;
    localparam t_func FUNC_WRITE = 3'd1;
    localparam t_func FUNC_SET   = 3'd2;
    localparam t_func FUNC_CLEAR = 3'd3;
    localparam t_func FUNC_ERET  = 3'd4;

    localparam t_reg_idx REG_STATUS = 5'd12;
    localparam t_reg_idx REG_CAUSE  = 5'd13;
    localparam t_reg_idx REG_PRID   = 5'd15;

    localparam t_word IP_MASK      = 32'h0000_FF00;
    localparam t_word STATUS_RESET = 32'h0040_0002;
    localparam t_word PRID_RESET   = 32'h0000_0002;

    typedef struct packed {
        t_func    func;
        t_reg_idx reg_index;
        t_word    write_data;
        logic [7:0] irq_lines;
    } t_op;

    typedef struct packed {
        t_word read_data;
        logic  irq_pending;
    } t_res;

endpackage
`default_nettype wire

FILE: src/scr_ifs.sv
// Valid/ready channel interfaces for operation items and results.
`default_nettype none
interface scr_item_if;
    import scr_pkg::*;
    logic       valid;
    logic       ready;
    t_func      func;
    t_reg_idx   reg_index;
    t_word      write_data;
    logic [7:0] irq_lines;

    modport source (output valid, func, reg_index, write_data, irq_lines, input ready);
    modport sink   (input valid, func, reg_index, write_data, irq_lines, output ready);
    modport mon    (input valid, ready, func, reg_index, write_data, irq_lines);
endinterface

interface scr_result_if;
    import scr_pkg::*;
    logic  valid;
    logic  ready;
    t_word read_data;
    logic  irq_pending;

    modport source (output valid, read_data, irq_pending, input ready);
    modport sink   (input valid, read_data, irq_pending, output ready);
    modport mon    (input valid, ready, read_data, irq_pending);
endinterface
`default_nettype wire

FILE: src/scr_regfile.sv
// Control register file with the single-pass operation logic.
`default_nettype none
module scr_regfile (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_exec,
    input  scr_pkg::t_op i_op,
    input  scr_pkg::t_word i_prid,
    output scr_pkg::t_res o_res
);
    import scr_pkg::*;

    t_word r_regs [REG_COUNT];
    t_word cur_status;
    t_word cur_cause;
    t_word n_status;
    t_word n_cause;
    t_word rd;

    assign cur_status = r_regs[REG_STATUS];
    assign cur_cause  = r_regs[REG_CAUSE];

    always_comb begin
        n_status = cur_status;
        n_cause  = cur_cause;
        rd       = '0;
        case (i_op.func)
            FUNC_READ: begin
                rd = (i_op.reg_index == REG_PRID) ? i_prid : r_regs[i_op.reg_index];
            end
            FUNC_WRITE: begin
                if (i_op.reg_index == REG_STATUS) begin
                    n_status = i_op.write_data;
                end
                if (i_op.reg_index == REG_CAUSE) begin
                    n_cause = (i_op.write_data & ~IP_MASK) | (cur_cause & IP_MASK);
                end
            end
            FUNC_SET: begin
                n_cause = cur_cause | {16'h0000, i_op.irq_lines, 8'h00};
            end
            FUNC_CLEAR: begin
                n_cause = cur_cause & ~{16'h0000, i_op.irq_lines, 8'h00};
            end
            FUNC_ERET: begin
                // pop the mode/enable stack by one level, keep the oldest pair
                n_status = {cur_status[31:4], cur_status[5:2]};
            end
            default: begin
            end
        endcase
    end

    assign o_res.read_data   = rd;
    assign o_res.irq_pending = (|(n_cause[15:8] & n_status[15:8])) & n_status[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= (i == int'(REG_STATUS)) ? STATUS_RESET : '0;
            end
        end else if (i_exec) begin
            if (i_op.func == FUNC_WRITE && i_op.reg_index != REG_PRID &&
                i_op.reg_index != REG_STATUS && i_op.reg_index != REG_CAUSE) begin
                r_regs[i_op.reg_index] <= i_op.write_data;
            end
            r_regs[REG_STATUS] <= n_status;
            r_regs[REG_CAUSE]  <= n_cause;
        end
    end
endmodule
`default_nettype wire

FILE: src/system_coprocessor_registers_unit.sv
// Top level: system coprocessor register unit with input and result registers.
//
// Usage:
//   i_item carries one operation per transfer (read, write, set or clear
//   interrupt-pending bits, return from exception). o_result returns one
//   transfer per item: the read data (zero for anything but a read) and the
//   interrupt-pending flag as it stands after the operation.
//   i_cfg_wr_en / i_cfg_wr_data load the processor id returned by register 15;
//   write it only while no item is in flight.
// Timing:
//   An accepted item lands in the input register, executes against the
//   register file when it advances into the result register and is offered
//   on o_result from then on. One item per cycle is sustained while
//   o_result.ready stays high; the register file update is a single masked
//   read-modify-write between the input and result registers.
// Reset:
//   Synchronous, active low. Both stages empty, all registers zero except
//   Status (0x00400002), processor id back to 2.
// Stall:
//   When o_result.ready is low the result holds; the input register still
//   takes one more item, after which i_item.ready drops until the result moves.
`default_nettype none
module system_coprocessor_registers_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    scr_item_if.sink            i_item,
    scr_result_if.source        o_result,
    input  logic                i_cfg_wr_en,
    input  scr_pkg::t_word      i_cfg_wr_data
);
    import scr_pkg::*;

    t_word r_prid;
    logic  r_in_valid;
    t_op   r_in;
    logic  r_out_valid;
    t_res  r_out;
    t_res  exec_res;
    logic  advance;
    logic  in_xfer;

    // advance the input stage when the result slot is empty or draining
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign in_xfer        = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prid <= PRID_RESET;
        end else if (i_cfg_wr_en) begin
            r_prid <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.func       <= i_item.func;
            r_in.reg_index  <= i_item.reg_index;
            r_in.write_data <= i_item.write_data;
            r_in.irq_lines  <= i_item.irq_lines;
        end
    end

    scr_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (advance),
        .i_op    (r_in),
        .i_prid  (r_prid),
        .o_res   (exec_res)
    );

    // result register: load on advance, drop on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= exec_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = r_out.read_data;
    assign o_result.irq_pending = r_out.irq_pending;
endmodule
`default_nettype wire

FILE: src/scr_checker.sv
// Port-level checks for the system coprocessor register unit, bound to the top.
`default_nettype none
`include "system_coprocessor_registers_unit_defines.svh"
module scr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_item_valid,
    input logic           i_item_ready,
    input logic           i_result_valid,
    input logic           i_result_ready,
    input scr_pkg::t_word i_read_data,
    input logic           i_irq_pending
);

    // a stalled result holds its payload
    `SCR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_result_valid && !i_result_ready, i_result_valid && $stable(i_read_data) && $stable(i_irq_pending))

    // input backpressure only comes from a stalled result
    `SCR_ASSERT_NOW(a_bp, i_clk, i_rst_n, !i_item_ready, i_result_valid && !i_result_ready)

    // an accepted item is followed by a result on offer once it has left the input register
    `SCR_ASSERT_NEXT(a_lat, i_clk, i_rst_n, i_item_valid && i_item_ready, ##1 i_result_valid)
endmodule

bind system_coprocessor_registers_unit scr_checker u_scr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_result_valid (o_result.valid),
    .i_result_ready (o_result.ready),
    .i_read_data    (o_result.read_data),
    .i_irq_pending  (o_result.irq_pending)
);
`default_nettype wire
